// ===== hdl/deq_pkg.sv =====
// deq_pkg: shared types, constants and ring arithmetic for the double-ended queue
// used by deq_ram and double_ended_queue_core; depends on nothing else
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  // storage geometry
  localparam int CAPACITY    = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // fixed field widths of the request and result
  localparam int MODE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int IN_TDATA_W  = ((DATA_W + POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [ADDR_W:0]        addr_sum_t;
  typedef logic [VALUE_WIDTH-1:0] elem_t;
  typedef logic [COUNT_W-1:0]     count_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ_AT    = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_OUT_RANGE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // ram port bundle
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    elem_t wr_data;
    logic  rd_en;
    addr_t rd_addr;
  } ram_req_t;

  // (a + b) mod CAPACITY for a, b below CAPACITY
  function automatic addr_t ring_add(addr_t a, addr_t b);
    addr_sum_t sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= addr_sum_t'(CAPACITY)) begin
      sum = sum - addr_sum_t'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // keep the low bits of a signed input value
  function automatic elem_t to_store(logic [DATA_W-1:0] v);
    return elem_t'($signed(v));
  endfunction

  // sign-extend a stored value and report the low bits
  function automatic logic [DATA_W-1:0] to_out(elem_t v);
    return DATA_W'($signed(v));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/double_ended_queue_core.sv =====
// double_ended_queue_core: bounded deque in a ring buffer, one request in, one result out
// depends on deq_pkg and deq_ram
//
//  channel | dir | tdata (low bit up)                  | tuser
//  in_     | in  | push_value[31:0], position[41:32]   | mode[2:0]
//  out_    | out | read_value[31:0], count[42:32]      | status[1:0]
//
// pushes, failed pops and failed reads put their result straight into the result register
// a pop or read that succeeds goes through the store's registered read port, which
// returns the element in the cycle after the address is issued
// the result register lets a new request in while the last result is taken
// rst_n is synchronous, active low; the element store has no reset
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [deq_pkg::IN_TDATA_W-1:0]     in_tdata,   // push_value, position
  input  wire logic [deq_pkg::MODE_W-1:0]         in_tuser,   // mode
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic      [deq_pkg::OUT_TDATA_W-1:0]    out_tdata,  // read_value, count
  output logic      [deq_pkg::STATUS_W-1:0]       out_tuser   // status
);

  deq_pkg::addr_t   front_r, front_nxt;
  deq_pkg::count_t  count_r, count_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [deq_pkg::DATA_W-1:0] out_value_r, out_value_nxt;
  deq_pkg::status_t out_status_r, out_status_nxt;
  deq_pkg::count_t  out_count_r, out_count_nxt;

  deq_pkg::ram_req_t ram_req;
  deq_pkg::elem_t    ram_rd_data;

  logic [deq_pkg::DATA_W-1:0] push_value;
  logic [deq_pkg::POS_W-1:0]  position;
  deq_pkg::mode_t             mode;
  logic                       accept;
  logic                       is_full;
  logic                       is_empty;
  deq_pkg::addr_t             cnt_addr;
  deq_pkg::addr_t             back_addr;

  assign push_value = in_tdata[deq_pkg::DATA_W-1:0];
  assign position   = in_tdata[deq_pkg::DATA_W +: deq_pkg::POS_W];
  assign mode       = deq_pkg::mode_t'(in_tuser);

  // one request in flight; output register free or being drained
  assign in_tready = !rd_pend_r && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign is_full   = (count_r >= deq_pkg::count_t'(deq_pkg::CAPACITY));
  assign is_empty  = (count_r == '0);
  assign cnt_addr  = count_r[deq_pkg::ADDR_W-1:0];
  assign back_addr = deq_pkg::ring_add(front_r, cnt_addr - deq_pkg::addr_t'(1));

  // operation decode, pointer update and store access
  always_comb begin
    front_nxt      = front_r;
    count_nxt      = count_r;
    rd_pend_nxt    = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_req        = '0;
    ram_req.wr_data = deq_pkg::to_store(push_value);

    // element arrives from the store
    if (rd_pend_r) begin
      out_value_nxt = deq_pkg::to_out(ram_rd_data);
      out_valid_nxt = 1'b1;
    end

    if (accept) begin
      out_value_nxt  = '0;
      out_status_nxt = deq_pkg::ST_OK;
      out_valid_nxt  = 1'b1;
      unique case (mode)
        deq_pkg::MODE_PUSH_FRONT: begin
          if (is_full) begin
            out_status_nxt = deq_pkg::ST_FULL;
          end else begin
            front_nxt       = deq_pkg::ring_add(front_r,
                                deq_pkg::addr_t'(deq_pkg::CAPACITY - 1));
            count_nxt       = count_r + deq_pkg::count_t'(1);
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = front_nxt;
          end
        end
        deq_pkg::MODE_PUSH_BACK: begin
          if (is_full) begin
            out_status_nxt = deq_pkg::ST_FULL;
          end else begin
            count_nxt       = count_r + deq_pkg::count_t'(1);
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = deq_pkg::ring_add(front_r, cnt_addr);
          end
        end
        deq_pkg::MODE_POP_FRONT: begin
          if (is_empty) begin
            out_status_nxt = deq_pkg::ST_EMPTY;
          end else begin
            front_nxt       = deq_pkg::ring_add(front_r, deq_pkg::addr_t'(1));
            count_nxt       = count_r - deq_pkg::count_t'(1);
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = front_r;
            rd_pend_nxt     = 1'b1;
            out_valid_nxt   = 1'b0;
          end
        end
        deq_pkg::MODE_POP_BACK: begin
          if (is_empty) begin
            out_status_nxt = deq_pkg::ST_EMPTY;
          end else begin
            count_nxt       = count_r - deq_pkg::count_t'(1);
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = back_addr;
            rd_pend_nxt     = 1'b1;
            out_valid_nxt   = 1'b0;
          end
        end
        deq_pkg::MODE_READ_AT: begin
          if (deq_pkg::count_t'(position) >= count_r) begin
            out_status_nxt = deq_pkg::ST_OUT_RANGE;
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = deq_pkg::ring_add(front_r,
                                position[deq_pkg::ADDR_W-1:0]);
            rd_pend_nxt     = 1'b1;
            out_valid_nxt   = 1'b0;
          end
        end
        default: begin
          // unused mode codes: no operation
        end
      endcase
      out_count_nxt = count_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  deq_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = deq_pkg::OUT_TDATA_W'({out_count_r, out_value_r});
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

// ===== hdl/deq_ram.sv =====
// deq_ram: single-clock element store, one write and one registered read port
// depends on deq_pkg for geometry and the request bundle
`timescale 1ns / 1ps
`default_nettype none

module deq_ram (
  input  wire logic              clk,
  input  wire deq_pkg::ram_req_t req,
  output deq_pkg::elem_t         rd_data
);

  deq_pkg::elem_t mem [deq_pkg::CAPACITY];
  deq_pkg::elem_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== bench/double_ended_queue_core_test.sv =====
// double_ended_queue_core_test: self-checking bench for the ring-buffer deque core
// drives random and directed requests over the in_ stream and checks every out_ result
// against a shadow deque; depends on deq_pkg and double_ended_queue_core
`timescale 1ns / 1ps

module double_ended_queue_core_test;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_WAIT = 16;
  localparam int POS_MAX    = (1 << deq_pkg::POS_W) - 1;

  typedef struct {
    deq_pkg::mode_t             mode;
    logic [deq_pkg::DATA_W-1:0] value;
    logic [deq_pkg::POS_W-1:0]  pos;
  } deq_req_t;

  typedef struct {
    logic [deq_pkg::DATA_W-1:0] value;
    deq_pkg::status_t           status;
    deq_pkg::count_t            count;
  } deq_res_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [deq_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;   // push_value, position
  logic [deq_pkg::MODE_W-1:0]      in_tuser   = '0;   // mode
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [deq_pkg::OUT_TDATA_W-1:0] out_tdata;         // read_value, count
  logic [deq_pkg::STATUS_W-1:0]    out_tuser;         // status

  double_ended_queue_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow deque
  deq_pkg::elem_t shadow_store [deq_pkg::CAPACITY];
  int    shadow_front = 0;
  int    shadow_count = 0;
  int    peak_count   = 0;
  int    n_empty      = 0;
  int    n_range      = 0;
  int    n_full       = 0;

  // request and result queues
  deq_req_t pending [$];
  deq_res_t expected [$];
  deq_res_t head_res;
  int       plan_count    = 0;
  int       accepted_reqs = 0;
  int       checked       = 0;
  int       error_count   = 0;

  // pacing state
  int          burst_left    = 0;
  int          gap_left      = 0;
  int          idle_cycles   = 0;
  logic [31:0] cycle_ctr     = '0;
  logic [15:0] stall_pattern = 16'hffff;
  logic        calm;

  // one quarter of the time neither side idles
  assign calm = (cycle_ctr[9:8] == 2'b00);

  // apply one request to the shadow deque and return its result
  function automatic deq_res_t apply_request(deq_req_t r);
    deq_res_t res;
    int       slot;
    res.value  = '0;
    res.status = deq_pkg::ST_OK;
    case (r.mode)
      deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK: begin
        if (shadow_count >= deq_pkg::CAPACITY) begin
          res.status = deq_pkg::ST_FULL;
          n_full++;
        end else begin
          if (r.mode == deq_pkg::MODE_PUSH_FRONT) begin
            shadow_front = (shadow_front + deq_pkg::CAPACITY - 1) % deq_pkg::CAPACITY;
            slot = shadow_front;
          end else begin
            slot = (shadow_front + shadow_count) % deq_pkg::CAPACITY;
          end
          shadow_store[slot] = deq_pkg::elem_t'(r.value);
          shadow_count++;
        end
      end
      deq_pkg::MODE_POP_FRONT: begin
        if (shadow_count == 0) begin
          res.status = deq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          res.value = deq_pkg::DATA_W'($signed(shadow_store[shadow_front]));
          shadow_front = (shadow_front + 1) % deq_pkg::CAPACITY;
          shadow_count--;
        end
      end
      deq_pkg::MODE_POP_BACK: begin
        if (shadow_count == 0) begin
          res.status = deq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          shadow_count--;
          slot = (shadow_front + shadow_count) % deq_pkg::CAPACITY;
          res.value = deq_pkg::DATA_W'($signed(shadow_store[slot]));
        end
      end
      deq_pkg::MODE_READ_AT: begin
        if (int'(r.pos) >= shadow_count) begin
          res.status = deq_pkg::ST_OUT_RANGE;
          n_range++;
        end else begin
          slot = (shadow_front + int'(r.pos)) % deq_pkg::CAPACITY;
          res.value = deq_pkg::DATA_W'($signed(shadow_store[slot]));
        end
      end
      default: ;
    endcase
    res.count = deq_pkg::count_t'(shadow_count);
    if (shadow_count > peak_count) peak_count = shadow_count;
    return res;
  endfunction

  // queue a request and track the fill level it leads to
  task automatic add_req(deq_pkg::mode_t m, logic [deq_pkg::DATA_W-1:0] v, int p);
    deq_req_t r;
    r.mode  = m;
    r.value = v;
    r.pos   = deq_pkg::POS_W'(p);
    pending.push_back(r);
    case (m)
      deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_BACK:
        if (plan_count < deq_pkg::CAPACITY) plan_count++;
      deq_pkg::MODE_POP_FRONT, deq_pkg::MODE_POP_BACK:
        if (plan_count > 0) plan_count--;
      default: ;
    endcase
  endtask

  // element values, leaning on the sign boundaries
  function automatic logic [deq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // read index near the fill level, sometimes anywhere
  function automatic int pick_pos();
    int p;
    case ($urandom_range(0, 3))
      0:       p = $urandom_range(0, POS_MAX);
      1:       p = plan_count;
      2:       p = plan_count - 1;
      default: p = (plan_count > 0) ? $urandom_range(0, plan_count - 1) : 0;
    endcase
    if (p < 0) p = 0;
    if (p > POS_MAX) p = POS_MAX;
    return p;
  endfunction

  // one random request with weighted operation choice
  task automatic add_random(int push_w, int pop_w, int read_w);
    int pick;
    pick = $urandom_range(0, push_w + pop_w + read_w - 1);
    if (pick < push_w) begin
      add_req($urandom_range(0, 1) ? deq_pkg::MODE_PUSH_BACK : deq_pkg::MODE_PUSH_FRONT,
              pick_value(), $urandom_range(0, POS_MAX));
    end else if (pick < push_w + pop_w) begin
      add_req($urandom_range(0, 1) ? deq_pkg::MODE_POP_BACK : deq_pkg::MODE_POP_FRONT,
              $urandom, $urandom_range(0, POS_MAX));
    end else begin
      add_req(deq_pkg::MODE_READ_AT, $urandom, pick_pos());
    end
  endtask

  task automatic report_mismatch(string what, logic [deq_pkg::DATA_W-1:0] got,
                                 logic [deq_pkg::DATA_W-1:0] want);
    if (error_count < 40)
      $display("mismatch at result %0d: %s got %h expected %h", checked, what, got, want);
    error_count++;
  endtask

  // request driver: bursts with random gaps, holds each request until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) begin
        expected.push_back(apply_request(pending.pop_front()));
        accepted_reqs++;
      end
      if (gap_left > 0 && !calm) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending.size() > 0) begin
        in_tdata  <= deq_pkg::IN_TDATA_W'({pending[0].pos, pending[0].value});
        in_tuser  <= pending[0].mode;
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                   : $urandom_range(0, 3);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: rotating stall pattern, reloaded when the low six cycle_ctr bits are zero
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (cycle_ctr[5:0] == 6'd0)
        stall_pattern = ($urandom_range(0, 1) ? 16'($urandom) | 16'($urandom) : 16'($urandom))
                        | 16'h0001;
      else
        stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      out_tready <= calm || stall_pattern[0];
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected.size() == 0) begin
        report_mismatch("result with no request outstanding",
                        out_tdata[deq_pkg::DATA_W-1:0], '0);
      end else begin
        head_res = expected.pop_front();
        if (out_tdata[deq_pkg::DATA_W-1:0] !== head_res.value)
          report_mismatch("read_value", out_tdata[deq_pkg::DATA_W-1:0], head_res.value);
        if (out_tuser !== head_res.status)
          report_mismatch("status", deq_pkg::DATA_W'(out_tuser),
                          deq_pkg::DATA_W'(head_res.status));
        if (out_tdata[deq_pkg::DATA_W +: deq_pkg::COUNT_W] !== head_res.count)
          report_mismatch("count",
                          deq_pkg::DATA_W'(out_tdata[deq_pkg::DATA_W +: deq_pkg::COUNT_W]),
                          deq_pkg::DATA_W'(head_res.count));
        checked++;
      end
    end
  end

  // watchdog on cycles without progress while work is outstanding
  always @(posedge clk) begin
    cycle_ctr <= cycle_ctr + 1;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (pending.size() == 0 && expected.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d requests and %0d results outstanding",
               idle_cycles, pending.size(), expected.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    // empty queue: both pops and reads at the index extremes fail
    add_req(deq_pkg::MODE_POP_FRONT, 32'h0000_0000, 0);
    add_req(deq_pkg::MODE_POP_BACK, 32'hffff_ffff, POS_MAX);
    add_req(deq_pkg::MODE_READ_AT, 32'h0000_0000, 0);
    add_req(deq_pkg::MODE_READ_AT, 32'hffff_ffff, POS_MAX);
    // front push wraps the pointer below address zero
    add_req(deq_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 0);
    add_req(deq_pkg::MODE_PUSH_BACK, 32'h7fff_ffff, POS_MAX);
    add_req(deq_pkg::MODE_PUSH_FRONT, 32'hffff_ffff, 512);
    add_req(deq_pkg::MODE_PUSH_BACK, 32'h0000_0000, 0);
    add_req(deq_pkg::MODE_PUSH_BACK, 32'h5555_aaaa, 0);
    // reads inside, at the count and far beyond it
    add_req(deq_pkg::MODE_READ_AT, 32'h0000_0000, 0);
    add_req(deq_pkg::MODE_READ_AT, 32'h0000_0000, 4);
    add_req(deq_pkg::MODE_READ_AT, 32'h0000_0000, 5);
    add_req(deq_pkg::MODE_READ_AT, 32'h0000_0000, POS_MAX);
    add_req(deq_pkg::MODE_READ_AT, 32'h0000_0000, 2);
    // drain from both ends past empty
    add_req(deq_pkg::MODE_POP_FRONT, 32'h0000_0000, 0);
    add_req(deq_pkg::MODE_POP_BACK, 32'h0000_0000, 0);
    add_req(deq_pkg::MODE_POP_BACK, 32'h0000_0000, 0);
    add_req(deq_pkg::MODE_POP_FRONT, 32'h0000_0000, 0);
    add_req(deq_pkg::MODE_POP_FRONT, 32'h0000_0000, 0);
    add_req(deq_pkg::MODE_POP_FRONT, 32'h0000_0000, 0);
    add_req(deq_pkg::MODE_POP_BACK, 32'h0000_0000, 0);
    // single element seen from the other end
    add_req(deq_pkg::MODE_PUSH_FRONT, 32'h0000_1234, 0);
    add_req(deq_pkg::MODE_POP_BACK, 32'h0000_0000, 0);

    // balanced mix around a shallow fill level
    repeat (200) add_random(2, 2, 1);
    // fill to capacity, then push on full and read the far end
    while (plan_count < deq_pkg::CAPACITY) add_random(23, 0, 2);
    repeat (4)
      add_req($urandom_range(0, 1) ? deq_pkg::MODE_PUSH_BACK : deq_pkg::MODE_PUSH_FRONT,
              pick_value(), 0);
    add_req(deq_pkg::MODE_READ_AT, 32'h0000_0000, POS_MAX);
    add_req(deq_pkg::MODE_READ_AT, 32'h0000_0000, 0);
    add_req(deq_pkg::MODE_POP_BACK, 32'h0000_0000, 0);
    add_req(deq_pkg::MODE_PUSH_FRONT, pick_value(), 0);
    add_req(deq_pkg::MODE_PUSH_BACK, pick_value(), 0);
    // mostly pops from a deep queue
    repeat (350) add_random(1, 6, 2);
    repeat (150) add_random(2, 2, 1);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending.size() != 0 || in_tvalid || expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d requests and %0d checked results, fill level up to %0d",
             accepted_reqs, checked, peak_count);
    $display("error paths hit: %0d empty pops, %0d out-of-range reads, %0d pushes on full",
             n_empty, n_range, n_full);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue_core.f =====
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/double_ended_queue_core.sv
bench/double_ended_queue_core_test.sv
